// ===== rtl/acr_pkg.sv =====
package acr_pkg;

  localparam int unsigned CNT_W         = 17;
  localparam int unsigned MAX_ALIGN_LEN = 65536;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [CNT_W:0]   SAT_LIMIT = (CNT_W + 1)'(MAX_ALIGN_LEN);
  localparam logic [CNT_W-1:0] SAT_VALUE = CNT_W'(MAX_ALIGN_LEN);

  typedef enum logic [1:0] {
    OP_MATCH    = 2'd0,
    OP_MISMATCH = 2'd1,
    OP_REF_GAP  = 2'd2,
    OP_QRY_GAP  = 2'd3
  } edit_op_t;

  localparam logic [3:0] CIGAR_M  = 4'd0;
  localparam logic [3:0] CIGAR_I  = 4'd1;
  localparam logic [3:0] CIGAR_D  = 4'd2;
  localparam logic [3:0] CIGAR_EQ = 4'd7;
  localparam logic [3:0] CIGAR_X  = 4'd8;

  typedef struct packed {
    logic       ref_gap;
    logic       ins;
    logic       is_edit;
    logic [3:0] code;
    logic       last;
  } item_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > SAT_LIMIT) ? SAT_VALUE : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/acr_front.sv =====
module acr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_tvalid,
  input  logic [23:0]   in_tdata,
  input  logic          in_tlast,
  input  logic          q_ready,
  output logic          q_push,
  output acr_pkg::item_t q_item
);
  import acr_pkg::*;

  logic     ext_r;
  logic     ext_nxt;
  edit_op_t op;
  logic     match;

  assign ext_nxt = cfg_we ? cfg_wdata : ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 1'b1;
    end else begin
      ext_r <= ext_nxt;
    end
  end

  always_comb begin
    op    = edit_op_t'(in_tdata[1:0]);
    match = (op == OP_MATCH) && (in_tdata[9:2] == in_tdata[17:10]);
    q_item.ref_gap = (op == OP_REF_GAP);
    q_item.ins     = (op == OP_QRY_GAP);
    q_item.is_edit = !match;
    q_item.last    = in_tlast;
    if (op == OP_QRY_GAP) begin
      q_item.code = CIGAR_I;
    end else if (ext_r) begin
      q_item.code = match ? CIGAR_EQ : CIGAR_X;
    end else begin
      q_item.code = CIGAR_M;
    end
  end

  assign q_push = in_tvalid && q_ready;

endmodule

// ===== rtl/acr_queue.sv =====
module acr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  acr_pkg::item_t wr_item,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output acr_pkg::item_t head
);
  import acr_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_pop;

  assign ready  = (count_r != QCNT_W'(QDEPTH));
  assign valid  = (count_r != '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ready)
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/acr_back.sv =====
module acr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  acr_pkg::item_t hd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [71:0]    out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);
  import acr_pkg::*;

  typedef enum logic [1:0] {PH_A, PH_B, PH_C} phase_t;

  phase_t            ph_r, ph_nxt;
  logic              lead_r, lead_nxt;
  logic [CNT_W-1:0]  lead_cnt_r, lead_cnt_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [3:0]        run_code_r, run_code_nxt;
  logic [CNT_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic              run_open_r, run_open_nxt;
  logic [CNT_W-1:0]  edit_r, edit_nxt;
  logic [CNT_W-1:0]  refpos_r, refpos_nxt;

  logic              ovalid_r;
  logic              ouser_r;
  logic              olast_r;
  logic [71:0]       odata_r;

  logic              emit_a, emit_b, emit_c, emit, done, go, out_free;
  logic              e_valid, e_final;
  logic [3:0]        e_code;
  logic [CNT_W-1:0]  e_len, e_edit, e_start, e_stop;

  assign out_free = !ovalid_r || out_tready;

  always_comb begin
    ph_nxt       = ph_r;
    lead_nxt     = lead_r;
    lead_cnt_nxt = lead_cnt_r;
    pend_nxt     = pend_r;
    run_code_nxt = run_code_r;
    run_cnt_nxt  = run_cnt_r;
    run_open_nxt = run_open_r;
    edit_nxt     = edit_r;
    refpos_nxt   = refpos_r;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    emit_c  = 1'b0;
    done    = 1'b0;
    e_valid = 1'b0;
    e_final = 1'b0;
    e_code  = '0;
    e_len   = '0;
    e_edit  = '0;
    e_start = '0;
    e_stop  = '0;

    if (ph_r == PH_A && !hd.ref_gap && pend_r != '0) begin
      if (run_open_r && run_code_r == CIGAR_D) begin
        run_cnt_nxt = sat_add(run_cnt_r, pend_r);
      end else begin
        emit_a       = run_open_r;
        e_valid      = 1'b1;
        e_code       = run_code_r;
        e_len        = run_cnt_r;
        run_code_nxt = CIGAR_D;
        run_cnt_nxt  = pend_r;
      end
      run_open_nxt = 1'b1;
      edit_nxt     = sat_add(edit_r, pend_r);
      refpos_nxt   = sat_add(refpos_r, pend_r);
      pend_nxt     = '0;
    end

    if (!emit_a && ph_r != PH_C) begin
      if (hd.ref_gap) begin
        if (lead_nxt) begin
          lead_cnt_nxt = sat_add(lead_cnt_nxt, CNT_W'(1));
          refpos_nxt   = sat_add(refpos_nxt, CNT_W'(1));
        end else begin
          pend_nxt = sat_add(pend_nxt, CNT_W'(1));
        end
      end else begin
        lead_nxt = 1'b0;
        if (hd.is_edit) begin
          edit_nxt = sat_add(edit_nxt, CNT_W'(1));
        end
        if (!hd.ins) begin
          refpos_nxt = sat_add(refpos_nxt, CNT_W'(1));
        end
        if (run_open_nxt && run_code_nxt == hd.code) begin
          run_cnt_nxt = sat_add(run_cnt_nxt, CNT_W'(1));
        end else begin
          emit_b       = run_open_nxt;
          e_valid      = 1'b1;
          e_code       = run_code_nxt;
          e_len        = run_cnt_nxt;
          run_code_nxt = hd.code;
          run_cnt_nxt  = CNT_W'(1);
        end
        run_open_nxt = 1'b1;
      end
    end

    if (!emit_a && !emit_b && hd.last) begin
      emit_c       = 1'b1;
      e_valid      = run_open_nxt;
      e_code       = run_open_nxt ? run_code_nxt : '0;
      e_len        = run_open_nxt ? run_cnt_nxt : '0;
      e_final      = 1'b1;
      e_edit       = edit_nxt;
      e_start      = lead_cnt_nxt;
      e_stop       = refpos_nxt;
      lead_nxt     = 1'b1;
      lead_cnt_nxt = '0;
      pend_nxt     = '0;
      run_code_nxt = '0;
      run_cnt_nxt  = '0;
      run_open_nxt = 1'b0;
      edit_nxt     = '0;
      refpos_nxt   = '0;
    end

    if (emit_a) begin
      ph_nxt = PH_B;
    end else if (emit_b && hd.last) begin
      ph_nxt = PH_C;
    end else begin
      ph_nxt = PH_A;
      done   = 1'b1;
    end

    emit  = emit_a || emit_b || emit_c;
    go    = q_valid && (!emit || out_free);
    q_pop = go && done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_A;
      lead_r     <= 1'b1;
      lead_cnt_r <= '0;
      pend_r     <= '0;
      run_code_r <= '0;
      run_cnt_r  <= '0;
      run_open_r <= 1'b0;
      edit_r     <= '0;
      refpos_r   <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (go) begin
        ph_r       <= ph_nxt;
        lead_r     <= lead_nxt;
        lead_cnt_r <= lead_cnt_nxt;
        pend_r     <= pend_nxt;
        run_code_r <= run_code_nxt;
        run_cnt_r  <= run_cnt_nxt;
        run_open_r <= run_open_nxt;
        edit_r     <= edit_nxt;
        refpos_r   <= refpos_nxt;
      end
      if (go && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (go && emit) begin
      ouser_r <= e_valid;
      olast_r <= e_final;
      odata_r <= {e_stop, e_start, e_edit, e_len, e_code};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = odata_r;

`ifndef SYNTHESIS
  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit_c) |=> (lead_r && !run_open_r && pend_r == '0 && edit_r == '0))
    else $error("alignment state not cleared after final result");
  a_phase_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_A) |-> q_valid)
    else $error("partial item without queued item");
  a_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (run_cnt_r <= SAT_VALUE) && (pend_r <= SAT_VALUE))
    else $error("counter above saturation bound");
  a_no_pending_in_lead: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r |-> (pend_r == '0 && !run_open_r))
    else $error("pending gaps or run during leading gap");
`endif

endmodule

// ===== rtl/alignment_ops_to_cigar_runs.sv =====
// Results are registered for out_tvalid after the four-entry queue between front and back.
// Throughput: one beat per cycle while each beat closes at most one run and out_tready does
// not stall; the back part writes one result per cycle into the output register, so a beat
// with two or three results holds the queue head longer, and the queue absorbs the wait.
// Reset: rst_n clears the queue, the output valid flag and the alignment state, and sets
// extended_ops to 1.
module alignment_ops_to_cigar_runs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // edit_op, query_base, target_base, zero fill
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // cigar_code, run_length, edit_total, ref_start, ref_stop
  output logic        out_tuser,  // run_valid
  output logic        out_tlast
);
  import acr_pkg::*;

  item_t f_item;
  item_t q_head;
  logic  f_push;
  logic  q_ready;
  logic  q_valid;
  logic  q_pop;

  assign in_tready = q_ready;

  acr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (f_push),
    .q_item    (f_item)
  );

  acr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_item (f_item),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  acr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .hd         (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
